// ===== rtl/assert_macros.svh =====
// assertion helpers, clocked on clk, disabled in reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define TLC_ASSERT(name, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("tlc assertion failed");

`define TLC_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tlc assertion failed");

`endif

// ===== rtl/tlc_pkg.sv =====
`default_nettype none

package tlc_pkg;

    localparam int SLOTS   = 128;
    localparam int IDX_W   = $clog2(SLOTS);
    localparam int CNT_W   = $clog2(SLOTS + 1);
    localparam int CFG_W   = 8;
    localparam int ZOOM_W  = 5;
    localparam int COORD_W = 32;
    localparam int STAMP_W = 64;
    localparam int SLOT_W  = 7;
    localparam int IN_W    = 72;
    localparam int OUT_W   = 16;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_STORE  = 1'b1;

    typedef struct packed {
        logic [ZOOM_W-1:0]  zoom;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } key_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } rd_req_t;

    typedef struct packed {
        logic               valid;
        key_t               key;
        logic [STAMP_W-1:0] stamp;
    } rd_rsp_t;

    typedef struct packed {
        logic               key_we;
        logic               stamp_we;
        logic [IDX_W-1:0]   addr;
        key_t               key;
        logic [STAMP_W-1:0] stamp;
    } wr_req_t;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_WRITE = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/tile_key_lru_cache_tags_top.sv =====
`default_nettype none

// Fully associative LRU tag store for tile keys (zoom, x, y). A lookup finds the
// lowest valid slot holding the key, re-stamps it and returns hit and slot; a store
// with storable set fills the lowest invalid active slot, else the active slot with
// the smallest stamp (lowest index on a tie), and returns written and slot. Stamps
// come from a 64-bit counter bumped on every touch or fill. Slots are read one per
// cycle from the tag/stamp memory; a scan covers up to slots_in_use slots (0 or 128
// and above meaning all 128), and a store that is not storable skips it. One item
// is in flight at a time; the result sits in an output register, so the next item
// is taken while it waits. Write slots_in_use only while the block is idle; valid
// bits clear at reset, no clearing pass needed.

module tile_key_lru_cache_tags_top
    import tlc_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [CFG_W-1:0] cfg_data,        // slots_in_use
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire logic [IN_W-1:0]  s_axis_tdata,    // zoom, tile_x, tile_y, storable
    input  wire logic             s_axis_tuser,    // opcode
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    output logic [OUT_W-1:0]      m_axis_tdata     // hit, written, slot
);

    logic [CFG_W-1:0]  slots_in_use_reg;
    logic [CNT_W-1:0]  n_active;
    key_t              in_key;
    logic              in_storable;
    logic              out_hit;
    logic              out_written;
    logic [SLOT_W-1:0] out_slot;
    rd_req_t           rd_req;
    wr_req_t           wr_req;
    rd_rsp_t           rd_rsp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_in_use_reg <= CFG_W'(SLOTS);
        end
        else if (cfg_we)
        begin
            slots_in_use_reg <= cfg_data;
        end
    end

    assign n_active = (slots_in_use_reg == '0 || slots_in_use_reg >= CFG_W'(SLOTS))
                      ? CNT_W'(SLOTS) : CNT_W'(slots_in_use_reg);

    assign in_key.zoom = s_axis_tdata[ZOOM_W-1:0];
    assign in_key.x    = s_axis_tdata[ZOOM_W+COORD_W-1:ZOOM_W];
    assign in_key.y    = s_axis_tdata[ZOOM_W+2*COORD_W-1:ZOOM_W+COORD_W];
    assign in_storable = s_axis_tdata[ZOOM_W+2*COORD_W];

    tlc_store u_store (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_req (rd_req),
        .wr_req (wr_req),
        .rd_rsp (rd_rsp)
    );

    tlc_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .n_active    (n_active),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_op       (s_axis_tuser),
        .in_key      (in_key),
        .in_storable (in_storable),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_hit     (out_hit),
        .out_written (out_written),
        .out_slot    (out_slot),
        .rd_req      (rd_req),
        .wr_req      (wr_req),
        .rd_rsp      (rd_rsp)
    );

    assign m_axis_tdata = {(OUT_W-SLOT_W-2)'(0), out_slot, out_written, out_hit};

`include "assert_macros.svh"

    `TLC_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `TLC_ASSERT(a_hit_written_excl, !(m_axis_tvalid && out_hit && out_written))
    `TLC_ASSERT(a_slot_zero_on_none, !(m_axis_tvalid && !out_hit && !out_written && out_slot != '0))
    `TLC_ASSERT(a_single_write, !(wr_req.key_we && !wr_req.stamp_we))

endmodule

`default_nettype wire

// ===== rtl/tlc_store.sv =====
`default_nettype none

module tlc_store
    import tlc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire rd_req_t rd_req,
    input  wire wr_req_t wr_req,
    output rd_rsp_t      rd_rsp
);

    logic [SLOTS-1:0]   valid_reg;
    logic               valid_rd_reg;
    key_t               key_mem [SLOTS];
    logic [STAMP_W-1:0] stamp_mem [SLOTS];
    key_t               key_rd_reg;
    logic [STAMP_W-1:0] stamp_rd_reg;

    // valid bits: one flop per slot, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            valid_rd_reg <= 1'b0;
        end
        else
        begin
            if (wr_req.key_we)
            begin
                valid_reg[wr_req.addr] <= 1'b1;
            end
            if (rd_req.en)
            begin
                valid_rd_reg <= valid_reg[rd_req.addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_req.key_we)
        begin
            key_mem[wr_req.addr] <= wr_req.key;
        end
        if (wr_req.stamp_we)
        begin
            stamp_mem[wr_req.addr] <= wr_req.stamp;
        end
        if (rd_req.en)
        begin
            key_rd_reg   <= key_mem[rd_req.addr];
            stamp_rd_reg <= stamp_mem[rd_req.addr];
        end
    end

    assign rd_rsp.valid = valid_rd_reg;
    assign rd_rsp.key   = key_rd_reg;
    assign rd_rsp.stamp = stamp_rd_reg;

endmodule

`default_nettype wire

// ===== rtl/tlc_cmp.sv =====
`default_nettype none

module tlc_cmp
    import tlc_pkg::*;
(
    input  wire key_t               key_a,
    input  wire key_t               key_b,
    input  wire logic [STAMP_W-1:0] stamp_a,
    input  wire logic [STAMP_W-1:0] stamp_b,
    output logic                    key_eq,
    output logic                    stamp_lt
);

    assign key_eq   = (key_a == key_b);
    assign stamp_lt = (stamp_a < stamp_b);

endmodule

`default_nettype wire

// ===== rtl/tlc_ctrl.sv =====
`default_nettype none

module tlc_ctrl
    import tlc_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [CNT_W-1:0] n_active,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic             in_op,
    input  wire key_t             in_key,
    input  wire logic             in_storable,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic                  out_hit,
    output logic                  out_written,
    output logic [SLOT_W-1:0]     out_slot,
    output rd_req_t               rd_req,
    output wr_req_t               wr_req,
    input  wire rd_rsp_t          rd_rsp
);

    state_t             state_reg, state_next;
    logic               op_reg, op_next;
    key_t               key_reg, key_next;
    logic [CNT_W-1:0]   n_reg, n_next;
    logic [CNT_W-1:0]   iss_reg, iss_next;
    logic               chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0]   chk_idx_reg, chk_idx_next;
    logic [STAMP_W-1:0] oldest_reg, oldest_next;
    logic [IDX_W-1:0]   victim_reg, victim_next;
    logic [STAMP_W-1:0] ctr_reg, ctr_next;
    logic               hit_reg, hit_next;
    logic               written_reg, written_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_hit_reg, out_hit_next;
    logic               out_written_reg, out_written_next;
    logic [SLOT_W-1:0]  out_slot_reg, out_slot_next;

    logic               key_eq;
    logic               stamp_lt;
    logic               issue;
    logic               last;
    logic [STAMP_W-1:0] ctr_inc;

    tlc_cmp u_cmp (
        .key_a    (rd_rsp.key),
        .key_b    (key_reg),
        .stamp_a  (rd_rsp.stamp),
        .stamp_b  (oldest_reg),
        .key_eq   (key_eq),
        .stamp_lt (stamp_lt)
    );

    assign issue   = (iss_reg < n_reg);
    assign last    = ({1'b0, chk_idx_reg} == (n_reg - CNT_W'(1)));
    assign ctr_inc = ctr_reg + STAMP_W'(1);

    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        key_next         = key_reg;
        n_next           = n_reg;
        iss_next         = iss_reg;
        chk_vld_next     = 1'b0;
        chk_idx_next     = chk_idx_reg;
        oldest_next      = oldest_reg;
        victim_next      = victim_reg;
        ctr_next         = ctr_reg;
        hit_next         = hit_reg;
        written_next     = written_reg;
        slot_next        = slot_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_hit_next     = out_hit_reg;
        out_written_next = out_written_reg;
        out_slot_next    = out_slot_reg;

        rd_req.en       = 1'b0;
        rd_req.addr     = iss_reg[IDX_W-1:0];
        wr_req.key_we   = 1'b0;
        wr_req.stamp_we = 1'b0;
        wr_req.addr     = victim_reg;
        wr_req.key      = key_reg;
        wr_req.stamp    = ctr_inc;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next      = in_op;
                    key_next     = in_key;
                    n_next       = n_active;
                    iss_next     = '0;
                    oldest_next  = '1;
                    victim_next  = '0;
                    hit_next     = 1'b0;
                    written_next = 1'b0;
                    slot_next    = '0;
                    if (in_op == OP_STORE && !in_storable)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                // read slot iss while checking the slot read in the previous cycle
                if (issue)
                begin
                    rd_req.en = 1'b1;
                    iss_next  = iss_reg + CNT_W'(1);
                end
                chk_vld_next = issue;
                chk_idx_next = iss_reg[IDX_W-1:0];
                if (chk_vld_reg)
                begin
                    if (op_reg == OP_LOOKUP)
                    begin
                        if (rd_rsp.valid && key_eq)
                        begin
                            victim_next  = chk_idx_reg;
                            chk_vld_next = 1'b0;
                            state_next   = ST_WRITE;
                        end
                        else if (last)
                        begin
                            chk_vld_next = 1'b0;
                            state_next   = ST_DONE;
                        end
                    end
                    else
                    begin
                        if (!rd_rsp.valid)
                        begin
                            victim_next  = chk_idx_reg;
                            chk_vld_next = 1'b0;
                            state_next   = ST_WRITE;
                        end
                        else
                        begin
                            if (stamp_lt)
                            begin
                                oldest_next = rd_rsp.stamp;
                                victim_next = chk_idx_reg;
                            end
                            if (last)
                            begin
                                chk_vld_next = 1'b0;
                                state_next   = ST_WRITE;
                            end
                        end
                    end
                end
            end
            ST_WRITE:
            begin
                wr_req.stamp_we = 1'b1;
                wr_req.key_we   = (op_reg == OP_STORE);
                ctr_next        = ctr_inc;
                hit_next        = (op_reg == OP_LOOKUP);
                written_next    = (op_reg == OP_STORE);
                slot_next       = SLOT_W'(victim_reg);
                state_next      = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next   = 1'b1;
                    out_hit_next     = hit_reg;
                    out_written_next = written_reg;
                    out_slot_next    = slot_reg;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            chk_vld_reg   <= 1'b0;
            ctr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chk_vld_reg   <= chk_vld_next;
            ctr_reg       <= ctr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        key_reg         <= key_next;
        n_reg           <= n_next;
        iss_reg         <= iss_next;
        chk_idx_reg     <= chk_idx_next;
        oldest_reg      <= oldest_next;
        victim_reg      <= victim_next;
        hit_reg         <= hit_next;
        written_reg     <= written_next;
        slot_reg        <= slot_next;
        out_hit_reg     <= out_hit_next;
        out_written_reg <= out_written_next;
        out_slot_reg    <= out_slot_next;
    end

    assign in_ready    = (state_reg == ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign out_hit     = out_hit_reg;
    assign out_written = out_written_reg;
    assign out_slot    = out_slot_reg;

endmodule

`default_nettype wire
